[design/cpf_pkg.sv]
// Shared constants, codes and the mask combine function of the collision pair filter.
package cpf_pkg;

    // Collision group table geometry (group fields are 5 bits wide)
    localparam int GROUP_W     = 5;
    localparam int GROUP_COUNT = 1 << GROUP_W;
    localparam int MASK_W      = 64;
    localparam int HALF_W      = MASK_W / 2;

    // Stream word widths
    localparam int IN_FIELDS_W = 2 + 2 * GROUP_W + 2 * MASK_W + 1;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int VERDICT_W   = 3;
    localparam int OUT_DATA_W  = 8;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_OP_FIRST        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OP_SECOND       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OP_FINAL        = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PASS_VALUE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONSTANT_FIRST  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONSTANT_SECOND = 3'd5;

    // Mask operation codes
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_AND      = 3'd0;
    localparam logic [OP_W-1:0] OP_OR       = 3'd1;
    localparam logic [OP_W-1:0] OP_XOR      = 3'd2;
    localparam logic [OP_W-1:0] OP_NAND     = 3'd3;
    localparam logic [OP_W-1:0] OP_NOR      = 3'd4;
    localparam logic [OP_W-1:0] OP_XNOR     = 3'd5;
    localparam logic [OP_W-1:0] OP_SWAP_AND = 3'd6;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_WRITE   = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_TRIGGER = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_CONTACT = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_GROUP   = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_MASK    = 3'd4;

    typedef logic [MASK_W-1:0] mask_t;
    typedef logic [GROUP_COUNT-1:0] table_row_t;

    // Combine two masks; the unused code acts as and
    function automatic mask_t combine(input mask_t x, input mask_t y, input logic [OP_W-1:0] sel);
        mask_t r;
        unique case (sel)
            OP_OR:       r = x | y;
            OP_XOR:      r = x ^ y;
            OP_NAND:     r = ~(x & y);
            OP_NOR:      r = ~(x | y);
            OP_XNOR:     r = ~(x ^ y);
            OP_SWAP_AND: r = x & {y[HALF_W-1:0], y[MASK_W-1:HALF_W]};
            default:     r = x & y;
        endcase
        return r;
    endfunction

endpackage

[design/collision_pair_filter_unit.sv]
// Collision pair filter: group table lookup, mask logic and table writes.
// One pair or table write is accepted every clock cycle unless the result
// stream stalls. Its result word passes the input register, then the result
// register; the group table read, the three 64-bit mask operations and the
// OR reduction sit between them. A table write updates the entry and its mirror
// at the same edge, so an item right behind it already sees the new value.
// The 32x32 group table comes out of reset with every entry enabled, and
// configuration registers reset to zero; write them only while idle.
module collision_pair_filter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // trigger_a[0], trigger_b[1], group_a[6:2], group_b[11:7], mask_a[75:12],
    // mask_b[139:76], enable_flag[140], zero fill[143:141]
    input  logic [cpf_pkg::IN_DATA_W-1:0]      s_tdata,
    // mode[0]
    input  logic                               s_tuser,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // verdict[2:0], table_flag[3], zero fill[7:4]
    output logic [cpf_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cpf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cpf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cpf_pkg::*;

    // Configuration registers
    logic [OP_W-1:0] op_first_reg;
    logic [OP_W-1:0] op_second_reg;
    logic [OP_W-1:0] op_final_reg;
    logic            pass_value_reg;
    mask_t           constant_first_reg;
    mask_t           constant_second_reg;

    // Input register
    logic               in_valid_reg;
    logic               in_mode_reg;
    logic               in_trigger_a_reg;
    logic               in_trigger_b_reg;
    logic [GROUP_W-1:0] in_group_a_reg;
    logic [GROUP_W-1:0] in_group_b_reg;
    mask_t              in_mask_a_reg;
    mask_t              in_mask_b_reg;
    logic               in_enable_reg;

    // Result register
    logic                 out_valid_reg;
    logic [VERDICT_W-1:0] out_verdict_reg;
    logic                 out_flag_reg;
    logic [VERDICT_W-1:0] verdict_next;

    // Group table
    table_row_t table_reg  [GROUP_COUNT];
    table_row_t table_next [GROUP_COUNT];

    logic  advance;
    logic  table_write;
    logic  flag;
    mask_t res_a;
    mask_t res_b;
    mask_t res_final;
    logic  any_bit;

    // Handshake: a word moves on when the result register is free or draining
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - VERDICT_W - 1){1'b0}}, out_flag_reg, out_verdict_reg};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_first_reg        <= OP_AND;
            op_second_reg       <= OP_AND;
            op_final_reg        <= OP_AND;
            pass_value_reg      <= 1'b0;
            constant_first_reg  <= '0;
            constant_second_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OP_FIRST:        op_first_reg        <= cfg_data[OP_W-1:0];
                CFG_OP_SECOND:       op_second_reg       <= cfg_data[OP_W-1:0];
                CFG_OP_FINAL:        op_final_reg        <= cfg_data[OP_W-1:0];
                CFG_PASS_VALUE:      pass_value_reg      <= cfg_data[0];
                CFG_CONSTANT_FIRST:  constant_first_reg  <= cfg_data[MASK_W-1:0];
                CFG_CONSTANT_SECOND: constant_second_reg <= cfg_data[MASK_W-1:0];
                default:             ;
            endcase
        end
    end

    // Capture the input word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg      <= s_tuser;
            in_trigger_a_reg <= s_tdata[0];
            in_trigger_b_reg <= s_tdata[1];
            in_group_a_reg   <= s_tdata[2 +: GROUP_W];
            in_group_b_reg   <= s_tdata[2 + GROUP_W +: GROUP_W];
            in_mask_a_reg    <= s_tdata[2 + 2 * GROUP_W +: MASK_W];
            in_mask_b_reg    <= s_tdata[2 + 2 * GROUP_W + MASK_W +: MASK_W];
            in_enable_reg    <= s_tdata[2 + 2 * GROUP_W + 2 * MASK_W];
        end
    end

    // Look up the table entry; 5-bit groups always fall inside the table
    assign flag = table_reg[in_group_a_reg][in_group_b_reg];

    // Mask logic
    assign res_a     = combine(in_mask_a_reg, constant_first_reg, op_first_reg);
    assign res_b     = combine(in_mask_b_reg, constant_second_reg, op_second_reg);
    assign res_final = combine(res_a, res_b, op_final_reg);
    assign any_bit   = |res_final;

    // Pick the verdict
    always_comb
    begin
        if (in_mode_reg)
            verdict_next = VERDICT_WRITE;
        else if (in_trigger_a_reg || in_trigger_b_reg)
            verdict_next = VERDICT_TRIGGER;
        else if (!flag)
            verdict_next = VERDICT_GROUP;
        else if (any_bit == pass_value_reg)
            verdict_next = VERDICT_CONTACT;
        else
            verdict_next = VERDICT_MASK;
    end

    // Write the entry and its mirror
    assign table_write = advance && in_valid_reg && in_mode_reg;

    always_comb
    begin
        for (int r = 0; r < GROUP_COUNT; r++)
        begin
            table_next[r] = table_reg[r];
        end
        if (table_write)
        begin
            table_next[in_group_a_reg][in_group_b_reg] = in_enable_reg;
            table_next[in_group_b_reg][in_group_a_reg] = in_enable_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < GROUP_COUNT; r++)
            begin
                table_reg[r] <= '1;
            end
        end
        else
        begin
            for (int r = 0; r < GROUP_COUNT; r++)
            begin
                table_reg[r] <= table_next[r];
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_verdict_reg <= verdict_next;
            out_flag_reg    <= flag;
        end
    end

`ifndef ASSERT_OFF
    // Table stays symmetric at the looked-up pair
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |->
        table_reg[in_group_a_reg][in_group_b_reg] == table_reg[in_group_b_reg][in_group_a_reg])
    else $error("group table lost symmetry");

    // A table write lands the enable value
    assert property (@(posedge clk) disable iff (!rst_n)
        table_write |=> table_reg[$past(in_group_a_reg)][$past(in_group_b_reg)] == $past(in_enable_reg))
    else $error("table write did not take effect");

    // Write items answer with the write verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        table_write |=> out_valid_reg && out_verdict_reg == VERDICT_WRITE)
    else $error("write item gave wrong verdict");

    // Trigger pairs pass as trigger pairs
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_valid_reg && !in_mode_reg && (in_trigger_a_reg || in_trigger_b_reg))
        |=> out_verdict_reg == VERDICT_TRIGGER)
    else $error("trigger pair gave wrong verdict");

    // Verdict codes stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_verdict_reg <= VERDICT_MASK)
    else $error("verdict out of range");
`endif

endmodule

[verif/tb_collision_pair_filter_unit.sv]
// Testbench for the collision pair filter: directed pair table, then random pairs per setting.
module tb_collision_pair_filter_unit;
    import cpf_pkg::*;

    // Spare operation code, acts as and
    localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

    localparam int    DIRECTED_ROWS = 22;
    localparam int    PHASES        = 16;
    localparam int    PHASE_PAIRS   = 108;
    localparam int    DRAIN_CYCLES  = 6;
    localparam mask_t ALL_ONES      = '1;
    localparam mask_t ALL_ZEROS     = '0;
    localparam mask_t ODD_BITS      = 64'h5555_5555_5555_5555;
    localparam mask_t EVEN_BITS     = 64'haaaa_aaaa_aaaa_aaaa;

    typedef struct packed {
        logic                 mode;
        logic                 trig_a;
        logic                 trig_b;
        logic [GROUP_W-1:0]   group_a;
        logic [GROUP_W-1:0]   group_b;
        mask_t                mask_a;
        mask_t                mask_b;
        logic                 enable;
    } pair_t;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic                 table_flag;
    } outcome_t;

    typedef struct packed {
        logic                 mode;
        logic                 trig_a;
        logic                 trig_b;
        logic [GROUP_W-1:0]   group_a;
        logic [GROUP_W-1:0]   group_b;
        mask_t                mask_a;
        mask_t                mask_b;
        logic                 enable;
        logic                 typed;
        logic [VERDICT_W-1:0] verdict;
        logic                 table_flag;
    } script_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predictor state: group table and register shadows
    table_row_t      group_enable [GROUP_COUNT];
    logic [OP_W-1:0] cur_op_first     = OP_AND;
    logic [OP_W-1:0] cur_op_second    = OP_AND;
    logic [OP_W-1:0] cur_op_final     = OP_AND;
    logic            cur_pass_value   = 1'b0;
    mask_t           cur_const_first  = '0;
    mask_t           cur_const_second = '0;

    outcome_t    verdict_queue [$];
    outcome_t    head_outcome;
    script_row_t script [DIRECTED_ROWS];
    int          error_count   = 0;
    int          burst_left    = 0;
    int          pattern_age   = 0;
    logic [15:0] ready_pattern = 16'hffff;

    collision_pair_filter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Apply one mask operation
    function automatic mask_t merge_masks(input mask_t x, input mask_t y,
                                          input logic [OP_W-1:0] code);
        mask_t rotated;
        rotated = (y << HALF_W) | (y >> HALF_W);
        case (code)
            OP_OR:       return x | y;
            OP_XOR:      return x ^ y;
            OP_NAND:     return ~(x & y);
            OP_NOR:      return ~(x | y);
            OP_XNOR:     return ~(x ^ y);
            OP_SWAP_AND: return x & rotated;
            default:     return x & y;
        endcase
    endfunction

    // Predict the verdict of one pair and update the group table on writes
    function automatic outcome_t filter_pair(input pair_t p);
        outcome_t o;
        mask_t    first_m;
        mask_t    second_m;
        mask_t    final_m;
        o.table_flag = group_enable[p.group_a][p.group_b];
        if (p.mode)
        begin
            group_enable[p.group_a][p.group_b] = p.enable;
            group_enable[p.group_b][p.group_a] = p.enable;
            o.verdict = VERDICT_WRITE;
        end
        else if (p.trig_a || p.trig_b)
            o.verdict = VERDICT_TRIGGER;
        else if (!o.table_flag)
            o.verdict = VERDICT_GROUP;
        else
        begin
            first_m  = merge_masks(p.mask_a, cur_const_first, cur_op_first);
            second_m = merge_masks(p.mask_b, cur_const_second, cur_op_second);
            final_m  = merge_masks(first_m, second_m, cur_op_final);
            o.verdict = ((|final_m) == cur_pass_value) ? VERDICT_CONTACT : VERDICT_MASK;
        end
        return o;
    endfunction

    // Constant choices: extremes, one half set, or random
    function automatic mask_t pick_constant(input int sel);
        case (sel % 4)
            0:       return ALL_ZEROS;
            1:       return ALL_ONES;
            2:       return 64'hffff_ffff_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Masks biased toward values that clear or fill the combined result
    function automatic mask_t pick_mask(input mask_t k);
        mask_t rotated;
        rotated = {k[HALF_W-1:0], k[MASK_W-1:HALF_W]};
        case ($urandom_range(0, 7))
            0:       return ALL_ZEROS;
            1:       return ALL_ONES;
            2:       return mask_t'(1) << $urandom_range(0, MASK_W - 1);
            3:       return ~k;
            4:       return k;
            5:       return rotated;
            6:       return ~rotated;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random pair: mostly filters, some table writes, groups crowded at the top
    function automatic pair_t random_pair();
        pair_t p;
        p.mode    = ($urandom_range(0, 99) < 18);
        p.trig_a  = p.mode ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
        p.trig_b  = p.mode ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
        p.group_a = GROUP_W'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                  : $urandom_range(28, 31));
        p.group_b = GROUP_W'($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                  : $urandom_range(28, 31));
        p.mask_a  = pick_mask(cur_const_first);
        p.mask_b  = pick_mask(cur_const_second);
        p.enable  = 1'($urandom_range(0, 1));
        return p;
    endfunction

    // Send one pair word in bursts with random gaps; queue its verdict on acceptance
    task automatic send_pair(input pair_t p, input logic typed, input outcome_t typed_outcome);
        int       gap;
        outcome_t predicted;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= p.mode;
        s_tdata  <= {3'b000, p.enable, p.mask_b, p.mask_a, p.group_b, p.group_a,
                     p.trig_b, p.trig_a};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = filter_pair(p);
        verdict_queue.push_back(typed ? typed_outcome : predicted);
    endtask

    // Wait until every verdict is back, then let the pipeline settle
    task automatic drain();
        while (verdict_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all six registers, then update the shadows
    task automatic load_config(input logic [OP_W-1:0] op1, input logic [OP_W-1:0] op2,
                               input logic [OP_W-1:0] opf, input logic pv,
                               input mask_t c1, input mask_t c2);
        logic [CFG_INDEX_W-1:0] order [6];
        logic [CFG_DATA_W-1:0]  values [6];
        int                     i;
        order[0] = CFG_OP_FIRST;        values[0] = CFG_DATA_W'(op1);
        order[1] = CFG_OP_SECOND;       values[1] = CFG_DATA_W'(op2);
        order[2] = CFG_OP_FINAL;        values[2] = CFG_DATA_W'(opf);
        order[3] = CFG_PASS_VALUE;      values[3] = CFG_DATA_W'(pv);
        order[4] = CFG_CONSTANT_FIRST;  values[4] = c1;
        order[5] = CFG_CONSTANT_SECOND; values[5] = c2;
        for (i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= values[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cur_op_first     = op1;
        cur_op_second    = op2;
        cur_op_final     = opf;
        cur_pass_value   = pv;
        cur_const_first  = c1;
        cur_const_second = c2;
    endtask

    // Check result words and stall the result stream on a rotating pattern
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_queue.size() == 0)
            begin
                $error("result word %h with no pair pending", m_tdata);
                error_count++;
            end
            else
            begin
                head_outcome = verdict_queue.pop_front();
                if (m_tdata[VERDICT_W-1:0] !== head_outcome.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", head_outcome.verdict,
                           m_tdata[VERDICT_W-1:0]);
                    error_count++;
                end
                if (m_tdata[VERDICT_W] !== head_outcome.table_flag)
                begin
                    $error("table_flag: expected %0d, got %0d", head_outcome.table_flag,
                           m_tdata[VERDICT_W]);
                    error_count++;
                end
            end
        end
        if (pattern_age == 0)
        begin
            pattern_age   <= $urandom_range(20, 80);
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom | 1);
        end
        else
        begin
            pattern_age   <= pattern_age - 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
        m_tready <= ready_pattern[0];
    end

    // Stimulus
    initial
    begin
        int          k;
        int          n;
        script_row_t row;
        pair_t       p;
        outcome_t    typed_outcome;

        for (k = 0; k < GROUP_COUNT; k++)
            group_enable[k] = '1;

        // mode, trig_a, trig_b, group_a, group_b, mask_a, mask_b, enable,
        // typed, verdict, table_flag; reset settings pass every enabled pair
        script = '{
            '{1'b0, 1'b0, 1'b0, 5'd0,  5'd0,  ALL_ONES,  ALL_ONES,  1'b0,
              1'b1, VERDICT_CONTACT, 1'b1},
            '{1'b0, 1'b0, 1'b0, 5'd31, 5'd31, ALL_ZEROS, ALL_ZEROS, 1'b1,
              1'b1, VERDICT_CONTACT, 1'b1},
            '{1'b0, 1'b1, 1'b0, 5'd5,  5'd9,  ALL_ONES,  ALL_ZEROS, 1'b0,
              1'b1, VERDICT_TRIGGER, 1'b1},
            '{1'b0, 1'b0, 1'b1, 5'd9,  5'd5,  ALL_ZEROS, ALL_ONES,  1'b0,
              1'b1, VERDICT_TRIGGER, 1'b1},
            '{1'b0, 1'b1, 1'b1, 5'd31, 5'd0,  ALL_ONES,  ALL_ONES,  1'b1,
              1'b1, VERDICT_TRIGGER, 1'b1},
            '{1'b1, 1'b1, 1'b1, 5'd3,  5'd7,  ALL_ONES,  ALL_ONES,  1'b0,
              1'b1, VERDICT_WRITE,   1'b1},
            '{1'b0, 1'b0, 1'b0, 5'd7,  5'd3,  ALL_ONES,  ALL_ONES,  1'b0,
              1'b1, VERDICT_GROUP,   1'b0},
            '{1'b0, 1'b0, 1'b1, 5'd3,  5'd7,  ALL_ZEROS, ALL_ZEROS, 1'b0,
              1'b1, VERDICT_TRIGGER, 1'b0},
            '{1'b1, 1'b0, 1'b0, 5'd7,  5'd3,  ALL_ZEROS, ALL_ZEROS, 1'b0,
              1'b1, VERDICT_WRITE,   1'b0},
            '{1'b1, 1'b0, 1'b0, 5'd3,  5'd7,  ALL_ZEROS, ALL_ZEROS, 1'b1,
              1'b1, VERDICT_WRITE,   1'b0},
            '{1'b0, 1'b0, 1'b0, 5'd7,  5'd3,  ODD_BITS,  EVEN_BITS, 1'b0,
              1'b1, VERDICT_CONTACT, 1'b1},
            '{1'b1, 1'b0, 1'b0, 5'd31, 5'd0,  ALL_ONES,  ALL_ZEROS, 1'b0,
              1'b1, VERDICT_WRITE,   1'b1},
            '{1'b0, 1'b0, 1'b0, 5'd0,  5'd31, ALL_ONES,  ALL_ONES,  1'b0,
              1'b1, VERDICT_GROUP,   1'b0},
            '{1'b1, 1'b0, 1'b1, 5'd0,  5'd0,  ALL_ZEROS, ALL_ONES,  1'b0,
              1'b1, VERDICT_WRITE,   1'b1},
            '{1'b0, 1'b0, 1'b0, 5'd0,  5'd0,  ALL_ONES,  ALL_ONES,  1'b0,
              1'b1, VERDICT_GROUP,   1'b0},
            '{1'b1, 1'b1, 1'b0, 5'd0,  5'd0,  ALL_ONES,  ALL_ZEROS, 1'b1,
              1'b1, VERDICT_WRITE,   1'b0},
            '{1'b1, 1'b0, 1'b0, 5'd0,  5'd31, ALL_ZEROS, ALL_ZEROS, 1'b1,
              1'b1, VERDICT_WRITE,   1'b0},
            '{1'b0, 1'b0, 1'b0, 5'd31, 5'd0,  EVEN_BITS, ODD_BITS,  1'b0,
              1'b1, VERDICT_CONTACT, 1'b1},
            '{1'b1, 1'b0, 1'b0, 5'd31, 5'd31, ALL_ONES,  ALL_ONES,  1'b0,
              1'b1, VERDICT_WRITE,   1'b1},
            '{1'b0, 1'b0, 1'b0, 5'd31, 5'd31, ALL_ONES,  ALL_ONES,  1'b0,
              1'b1, VERDICT_GROUP,   1'b0},
            '{1'b1, 1'b0, 1'b0, 5'd31, 5'd31, ALL_ZEROS, ALL_ZEROS, 1'b1,
              1'b1, VERDICT_WRITE,   1'b0},
            '{1'b0, 1'b0, 1'b0, 5'd12, 5'd20, 64'h0123_4567_89ab_cdef,
              64'hfedc_ba98_7654_3210, 1'b0, 1'b0, VERDICT_WRITE, 1'b0}
        };

        // Hold reset, release on a clock edge
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table under reset settings
        for (n = 0; n < DIRECTED_ROWS; n++)
        begin
            row = script[n];
            p = '{row.mode, row.trig_a, row.trig_b, row.group_a, row.group_b,
                  row.mask_a, row.mask_b, row.enable};
            typed_outcome = '{row.verdict, row.table_flag};
            send_pair(p, row.typed, typed_outcome);
        end
        s_tvalid <= 1'b0;

        // Sweep every operation code per register, then random settings
        for (k = 0; k < PHASES; k++)
        begin
            drain();
            if (k < 8)
                load_config(OP_W'(k), OP_W'(OP_SPARE - k), OP_W'((k + 2) % 8), k[0],
                            pick_constant(k), pick_constant(k + 1));
            else
                load_config(OP_W'($urandom_range(0, 7)), OP_W'($urandom_range(0, 7)),
                            OP_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                            pick_constant($urandom_range(0, 3)),
                            pick_constant($urandom_range(0, 3)));
            for (n = 0; n < PHASE_PAIRS; n++)
                send_pair(random_pair(), 1'b0, '0);
            s_tvalid <= 1'b0;
        end

        drain();
        if (error_count == 0)
            $display("tb_collision_pair_filter_unit OK");
        else
            $display("tb_collision_pair_filter_unit NOT OK");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2000000;
        $display("tb_collision_pair_filter_unit NOT OK");
        $finish;
    end

endmodule
